[rtl/pss_pkg.sv]
// Package with shared types, codes, field widths, target clamp limit and reset constants of the swing-up sequencer.
`default_nettype none

package pss_pkg;

  // Run state codes, as reported on the run_state output.
  typedef enum logic [3:0] {
    MODE_STOP      = 4'd0,
    MODE_JUDGE     = 4'd1,
    MODE_L_START   = 4'd2,
    MODE_L_FIRST   = 4'd3,
    MODE_L_FLIP    = 4'd4,
    MODE_L_SECOND  = 4'd5,
    MODE_R_START   = 4'd6,
    MODE_R_FIRST   = 4'd7,
    MODE_R_FLIP    = 4'd8,
    MODE_R_SECOND  = 4'd9,
    MODE_BALANCE   = 4'd10
  } mode_e;

  // Key codes carried by each tick request.
  typedef enum logic [1:0] {
    KEY_NONE   = 2'd0,
    KEY_TOGGLE = 2'd1,
    KEY_UP     = 2'd2,
    KEY_DOWN   = 2'd3
  } key_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_CENTER_ANGLE   = 3'd0,
    CFG_CENTER_RANGE   = 3'd1,
    CFG_START_DRIVE    = 3'd2,
    CFG_START_TIME     = 3'd3,
    CFG_JUDGE_PERIOD   = 3'd4,
    CFG_ANGLE_PERIOD   = 3'd5,
    CFG_POSITION_PERIOD = 3'd6,
    CFG_TARGET_STEP    = 3'd7
  } cfg_idx_e;

  // Field widths.
  localparam int ANGLE_BITS = 12;
  localparam int TGT_W      = 14;

  // Clamp limit of the position target.
  localparam int TARGET_LIMIT = 4080;
  localparam logic signed [TGT_W:0] TGT_MAX = (TGT_W+1)'(TARGET_LIMIT);
  localparam logic signed [TGT_W:0] TGT_MIN = (TGT_W+1)'(-TARGET_LIMIT);

  // Register reset values.
  localparam logic [ANGLE_BITS-1:0] RST_CENTER_ANGLE = 12'd2010;
  localparam logic [10:0]           RST_CENTER_RANGE = 11'd500;
  localparam logic [6:0]            RST_START_DRIVE  = 7'd35;
  localparam logic [15:0]           RST_START_TIME   = 16'd100;
  localparam logic [15:0]           RST_JUDGE_PERIOD = 16'd40;
  localparam logic [15:0]           RST_ANGLE_PERIOD = 16'd5;
  localparam logic [15:0]           RST_POS_PERIOD   = 16'd50;
  localparam logic [11:0]           RST_TARGET_STEP  = 12'd408;

endpackage

`default_nettype wire

[rtl/pendulum_swing_up_sequencer.sv]
// Top level of the pendulum swing-up sequencer: tick handling, mode machine, configuration and result registers.
`default_nettype none

// Each accepted request is one 1 ms tick (key, angle, speed) and yields exactly one result
// in the following clock cycle. The whole tick is evaluated by one pass of compares,
// counters and adds between the state registers and the result register, so a new tick
// may be accepted in every clock cycle; the input is stalled only while a finished result
// waits and the output side is not taking it. Configuration writes are always accepted
// and take effect on the next tick; they are expected only while no tick is in flight.
module pendulum_swing_up_sequencer (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,

  // Configuration write channel.
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [15:0]        cfg_data_i,

  // Tick request channel.
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         key_code_i,
  input  wire logic [11:0]        angle_i,
  input  wire logic signed [15:0] speed_i,

  // Result channel.
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [3:0]              run_state_o,
  output logic signed [7:0]       drive_o,
  output logic                    pid_active_o,
  output logic                    angle_loop_due_o,
  output logic                    position_loop_due_o,
  output logic                    clear_integrals_o,
  output logic signed [15:0]      position_o,
  output logic signed [12:0]      position_target_o,
  output logic                    led_on_o
);

  // Configuration registers.
  logic [11:0] center_angle_q;
  logic [10:0] center_range_q;
  logic [6:0]  start_drive_q;
  logic [15:0] start_time_q;
  logic [15:0] judge_period_q;
  logic [15:0] angle_period_q;
  logic [15:0] pos_period_q;
  logic [11:0] target_step_q;

  // Sequencer state.
  pss_pkg::mode_e                 mode_q, mode_d, mode_k;
  logic signed [7:0]              held_q, held_d;
  logic [15:0]                    judge_cnt_q, judge_cnt_d;
  logic [15:0]                    inner_cnt_q, inner_cnt_d;
  logic [15:0]                    outer_cnt_q, outer_cnt_d;
  logic [15:0]                    timer_q, timer_d;
  logic [11:0]                    hist_q [3];
  logic [11:0]                    hist_d [3];
  logic [15:0]                    pos_q, pos_d;
  logic signed [pss_pkg::TGT_W-1:0] target_q, target_d;

  // Result register.
  logic        out_valid_q;
  logic [3:0]  run_state_q;
  logic signed [7:0] drive_q;
  logic        pid_q, adue_q, pdue_q, clr_q, led_q;
  logic signed [15:0] position_q;
  logic signed [12:0] target_out_q;

  logic pid_d, adue_d, pdue_d, clr_d;

  logic in_acc;
  logic cfg_acc;

  // Derived band limits and intermediate terms.
  logic signed [13:0] band_lo, band_hi;
  logic signed [pss_pkg::TGT_W:0] tgt_up, tgt_dn;
  logic [15:0] judge_inc, inner_inc, outer_inc, timer_dec;
  logic        judge_hit, timer_done;
  logic        peak_r, peak_l, band_pair, angle_ok;
  logic signed [13:0] a0, a1, a2;
  logic [15:0] pos_add;

  // Strict inside test of one sample against the centre band.
  function automatic logic in_band(input logic signed [13:0] a,
                                   input logic signed [13:0] lo,
                                   input logic signed [13:0] hi);
    in_band = (a > lo) && (a < hi);
  endfunction

  // Handshakes: the result register parts the two sides.
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i;

  // Centre band, computed without wrap.
  assign band_lo = $signed({2'b00, center_angle_q}) - $signed({3'b000, center_range_q});
  assign band_hi = $signed({2'b00, center_angle_q}) + $signed({3'b000, center_range_q});

  // Key handling on the mode.
  always_comb begin
    mode_k = mode_q;
    if (pss_pkg::key_e'(key_code_i) == pss_pkg::KEY_TOGGLE) begin
      mode_k = (mode_q == pss_pkg::MODE_STOP) ? pss_pkg::MODE_L_START : pss_pkg::MODE_STOP;
    end
  end

  // Key handling on the position target, with clamp.
  assign tgt_up = {target_q[pss_pkg::TGT_W-1], target_q} + $signed({3'b000, target_step_q});
  assign tgt_dn = {target_q[pss_pkg::TGT_W-1], target_q} - $signed({3'b000, target_step_q});

  always_comb begin
    target_d = target_q;
    case (pss_pkg::key_e'(key_code_i))
      pss_pkg::KEY_UP: begin
        target_d = (tgt_up > pss_pkg::TGT_MAX) ? pss_pkg::TGT_MAX[pss_pkg::TGT_W-1:0]
                                               : tgt_up[pss_pkg::TGT_W-1:0];
      end
      pss_pkg::KEY_DOWN: begin
        target_d = (tgt_dn < pss_pkg::TGT_MIN) ? pss_pkg::TGT_MIN[pss_pkg::TGT_W-1:0]
                                               : tgt_dn[pss_pkg::TGT_W-1:0];
      end
      default: begin
        target_d = target_q;
      end
    endcase
  end

  // Counters and timer arithmetic.
  assign judge_inc  = judge_cnt_q + 16'd1;
  assign inner_inc  = inner_cnt_q + 16'd1;
  assign outer_inc  = outer_cnt_q + 16'd1;
  assign timer_dec  = timer_q - 16'd1;
  assign judge_hit  = judge_inc >= judge_period_q;
  assign timer_done = timer_dec == 16'd0;
  assign pos_add    = pos_q + speed_i;

  // Swing judgement on the shifted angle history.
  assign a0 = $signed({2'b00, angle_i});
  assign a1 = $signed({2'b00, hist_q[0]});
  assign a2 = $signed({2'b00, hist_q[1]});
  assign peak_r = (a0 > band_hi) && (a1 > band_hi) && (a2 > band_hi) && (a1 < a0) && (a1 < a2);
  assign peak_l = (a0 < band_lo) && (a1 < band_lo) && (a2 < band_lo) && (a1 > a0) && (a1 > a2);
  assign band_pair = in_band(a0, band_lo, band_hi) && in_band(a1, band_lo, band_hi);
  assign angle_ok  = in_band(a0, band_lo, band_hi);

  // Next mode.
  always_comb begin
    mode_d = mode_k;
    case (mode_k)
      pss_pkg::MODE_JUDGE: begin
        if (judge_hit) begin
          if (band_pair) begin
            mode_d = pss_pkg::MODE_BALANCE;
          end else if (peak_l) begin
            mode_d = pss_pkg::MODE_R_START;
          end else if (peak_r) begin
            mode_d = pss_pkg::MODE_L_START;
          end
        end
      end
      pss_pkg::MODE_L_START:  mode_d = pss_pkg::MODE_L_FIRST;
      pss_pkg::MODE_L_FLIP:   mode_d = pss_pkg::MODE_L_SECOND;
      pss_pkg::MODE_R_START:  mode_d = pss_pkg::MODE_R_FIRST;
      pss_pkg::MODE_R_FLIP:   mode_d = pss_pkg::MODE_R_SECOND;
      pss_pkg::MODE_L_FIRST: begin
        if (timer_done) mode_d = pss_pkg::MODE_L_FLIP;
      end
      pss_pkg::MODE_R_FIRST: begin
        if (timer_done) mode_d = pss_pkg::MODE_R_FLIP;
      end
      pss_pkg::MODE_L_SECOND, pss_pkg::MODE_R_SECOND: begin
        if (timer_done) mode_d = pss_pkg::MODE_JUDGE;
      end
      pss_pkg::MODE_BALANCE: begin
        if (!angle_ok) mode_d = pss_pkg::MODE_STOP;
      end
      default: begin
        mode_d = pss_pkg::MODE_STOP;
      end
    endcase
  end

  // Datapath and strobes for the current mode.
  always_comb begin
    held_d      = held_q;
    judge_cnt_d = judge_cnt_q;
    inner_cnt_d = inner_cnt_q;
    outer_cnt_d = outer_cnt_q;
    timer_d     = timer_q;
    hist_d      = hist_q;
    pos_d       = pos_add;
    pid_d       = 1'b0;
    adue_d      = 1'b0;
    pdue_d      = 1'b0;
    clr_d       = 1'b0;
    case (mode_k)
      pss_pkg::MODE_JUDGE: begin
        judge_cnt_d = judge_inc;
        if (judge_hit) begin
          judge_cnt_d = 16'd0;
          hist_d[2]   = hist_q[1];
          hist_d[1]   = hist_q[0];
          hist_d[0]   = angle_i;
          if (band_pair) begin
            pos_d = 16'd0;
            clr_d = 1'b1;
          end
        end
      end
      pss_pkg::MODE_L_START, pss_pkg::MODE_R_FLIP: begin
        held_d  = $signed({1'b0, start_drive_q});
        timer_d = start_time_q;
      end
      pss_pkg::MODE_R_START, pss_pkg::MODE_L_FLIP: begin
        held_d  = -$signed({1'b0, start_drive_q});
        timer_d = start_time_q;
      end
      pss_pkg::MODE_L_FIRST, pss_pkg::MODE_R_FIRST: begin
        timer_d = timer_dec;
      end
      pss_pkg::MODE_L_SECOND, pss_pkg::MODE_R_SECOND: begin
        timer_d = timer_dec;
        if (timer_done) held_d = 8'sd0;
      end
      pss_pkg::MODE_BALANCE: begin
        pid_d       = 1'b1;
        inner_cnt_d = inner_inc;
        if (inner_inc >= angle_period_q) begin
          inner_cnt_d = 16'd0;
          adue_d      = 1'b1;
        end
        outer_cnt_d = outer_inc;
        if (outer_inc >= pos_period_q) begin
          outer_cnt_d = 16'd0;
          pdue_d      = 1'b1;
        end
      end
      default: begin
        held_d = 8'sd0;
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_angle_q <= pss_pkg::RST_CENTER_ANGLE;
      center_range_q <= pss_pkg::RST_CENTER_RANGE;
      start_drive_q  <= pss_pkg::RST_START_DRIVE;
      start_time_q   <= pss_pkg::RST_START_TIME;
      judge_period_q <= pss_pkg::RST_JUDGE_PERIOD;
      angle_period_q <= pss_pkg::RST_ANGLE_PERIOD;
      pos_period_q   <= pss_pkg::RST_POS_PERIOD;
      target_step_q  <= pss_pkg::RST_TARGET_STEP;
    end else if (cfg_acc) begin
      case (pss_pkg::cfg_idx_e'(cfg_index_i))
        pss_pkg::CFG_CENTER_ANGLE:    center_angle_q <= cfg_data_i[11:0];
        pss_pkg::CFG_CENTER_RANGE:    center_range_q <= cfg_data_i[10:0];
        pss_pkg::CFG_START_DRIVE:     start_drive_q  <= cfg_data_i[6:0];
        pss_pkg::CFG_START_TIME:      start_time_q   <= cfg_data_i;
        pss_pkg::CFG_JUDGE_PERIOD:    judge_period_q <= cfg_data_i;
        pss_pkg::CFG_ANGLE_PERIOD:    angle_period_q <= cfg_data_i;
        pss_pkg::CFG_POSITION_PERIOD: pos_period_q   <= cfg_data_i;
        pss_pkg::CFG_TARGET_STEP:     target_step_q  <= cfg_data_i[11:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer state, advanced once per accepted tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= pss_pkg::MODE_STOP;
      held_q      <= 8'sd0;
      judge_cnt_q <= 16'd0;
      inner_cnt_q <= 16'd0;
      outer_cnt_q <= 16'd0;
      timer_q     <= 16'd0;
      hist_q[0]   <= 12'd0;
      hist_q[1]   <= 12'd0;
      hist_q[2]   <= 12'd0;
      pos_q       <= 16'd0;
      target_q    <= '0;
    end else if (in_acc) begin
      mode_q      <= mode_d;
      held_q      <= held_d;
      judge_cnt_q <= judge_cnt_d;
      inner_cnt_q <= inner_cnt_d;
      outer_cnt_q <= outer_cnt_d;
      timer_q     <= timer_d;
      hist_q      <= hist_d;
      pos_q       <= pos_d;
      target_q    <= target_d;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      run_state_q  <= mode_d;
      drive_q      <= held_d;
      pid_q        <= pid_d;
      adue_q       <= adue_d;
      pdue_q       <= pdue_d;
      clr_q        <= clr_d;
      position_q   <= pos_d;
      target_out_q <= target_d[12:0];
      led_q        <= mode_d != pss_pkg::MODE_STOP;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign run_state_o         = run_state_q;
  assign drive_o             = drive_q;
  assign pid_active_o        = pid_q;
  assign angle_loop_due_o    = adue_q;
  assign position_loop_due_o = pdue_q;
  assign clear_integrals_o   = clr_q;
  assign position_o          = position_q;
  assign position_target_o   = target_out_q;
  assign led_on_o            = led_q;

  // Every accepted tick is followed by a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_acc |=> out_valid_o)
    else $error("accepted tick produced no result");

  // Loop strobes come only from a balance step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (angle_loop_due_o || position_loop_due_o) |-> pid_active_o)
    else $error("loop strobe outside balance step");

  // Balance entry never runs a balance step in the same tick.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && clear_integrals_o |-> !pid_active_o &&
    (run_state_o == pss_pkg::MODE_BALANCE))
    else $error("integral clear without balance entry");

  // Judge and balance never hold a sequencer drive.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((run_state_o == pss_pkg::MODE_JUDGE) ||
    (run_state_o == pss_pkg::MODE_BALANCE)) |-> (drive_o == 8'sd0))
    else $error("drive held in judge or balance");

endmodule

`default_nettype wire
